[hw/rtl/ise_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the interval statistics engine
package ise_pkg;

  localparam int unsigned StampW = 40;
  localparam int unsigned IvlW   = 32;
  localparam int unsigned CfgW   = 11;
  localparam logic [CfgW-1:0] CfgReset = 11'd1024;

  typedef struct packed {
    logic            last;
    logic [IvlW-1:0] interval;
  } ise_item_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_ACC,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RD4,
    S_MEAN_GO,
    S_MEAN_W,
    S_MUL1_GO,
    S_MUL1_W,
    S_MUL2_GO,
    S_MUL2_W,
    S_DIV1_GO,
    S_DIV1_W,
    S_DIV2_GO,
    S_DIV2_W,
    S_SQRT_GO,
    S_SQRT_W,
    S_OUT
  } back_state_e;

endpackage

[hw/rtl/ise_front.sv]
`timescale 1ns / 1ps
// front end: takes timestamps, forms saturated intervals and marks the end of a run
module ise_front #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [ise_pkg::CfgW-1:0] sample_count_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ise_pkg::StampW-1:0] timestamp_us_i,
  output logic                     push_o,
  output ise_pkg::ise_item_t       item_o,
  input  logic                     full_i
);
  import ise_pkg::*;

  localparam int unsigned NW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CW = (NW > CfgW) ? NW : CfgW;
  localparam logic [CW-1:0] MaxCw = CW'(MAX_SAMPLES);

  logic              have_ref_q, have_ref_d;
  logic [StampW-1:0] prev_q, prev_d;
  logic [NW-1:0]     cnt_q, cnt_d;
  logic [StampW-1:0] diff;
  logic [NW-1:0]     cnt_inc;
  logic [CW-1:0]     eff;
  logic              accept;
  logic              last;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign diff       = timestamp_us_i - prev_q;
  assign cnt_inc    = cnt_q + 1'b1;

  always_comb begin
    eff = CW'(sample_count_i);
    if (sample_count_i == '0) begin
      eff = CW'(1);
    end else if (eff > MaxCw) begin
      eff = MaxCw;
    end
  end

  assign last = (CW'(cnt_inc) >= eff);

  assign push_o        = accept && have_ref_q;
  assign item_o.last   = last;
  assign item_o.interval = (|diff[StampW-1:IvlW]) ? {IvlW{1'b1}} : diff[IvlW-1:0];

  always_comb begin
    have_ref_d = have_ref_q;
    prev_d     = prev_q;
    cnt_d      = cnt_q;
    if (accept) begin
      prev_d = timestamp_us_i;
      if (!have_ref_q) begin
        have_ref_d = 1'b1;
      end else if (last) begin
        have_ref_d = 1'b0;
        cnt_d      = '0;
      end else begin
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ref_q <= 1'b0;
      prev_q     <= '0;
      cnt_q      <= '0;
    end else begin
      have_ref_q <= have_ref_d;
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
    end
  end

endmodule

[hw/rtl/ise_fifo.sv]
`timescale 1ns / 1ps
// two-entry queue between front and back
module ise_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ise_pkg::ise_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ise_pkg::ise_item_t item_o
);
  import ise_pkg::*;

  ise_item_t   mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/ise_arith.sv]
`timescale 1ns / 1ps
// shared iterative unit: shift-add multiply, restoring divide, integer square root
module ise_arith #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ise_pkg::arith_req_t  req_i,
  input  logic [64+2*$clog2(MAX_SAMPLES+1)-1:0] a_i,
  input  logic [32+$clog2(MAX_SAMPLES+1)-1:0]   b_i,
  output logic                 done_o,
  output logic [64+2*$clog2(MAX_SAMPLES+1)-1:0] res_o
);
  import ise_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW   = 32 + NW;
  localparam int unsigned NUMW = 64 + 2 * NW;
  localparam int unsigned KW   = $clog2(NUMW + 1);

  logic            busy_q;
  logic            done_q;
  arith_op_e       op_q;
  logic [NUMW-1:0] acc_q;
  logic [NUMW-1:0] a_q;
  logic [SW-1:0]   b_q;
  logic [NW:0]     rem_q;
  logic [63:0]     one_q;
  logic [KW-1:0]   cnt_q;

  logic [NW:0]     rem_sh;
  logic            ge;
  logic [63:0]     trial;
  logic [63:0]     root;

  assign rem_sh = {rem_q[NW-1:0], a_q[NUMW-1]};
  assign ge     = (rem_sh >= {1'b0, b_q[NW-1:0]});
  assign root   = acc_q[63:0];
  assign trial  = root + one_q;

  assign done_o = done_q;
  assign res_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        case (op_q)
          OP_MUL: begin
            if (b_q == '0) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          OP_DIV: begin
            if (cnt_q == KW'(NUMW - 1)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          OP_SQRT: begin
            if (cnt_q == KW'(31)) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end
          end
          default: begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
      rem_q <= '0;
      one_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (b_q != '0) begin
            if (b_q[0]) begin
              acc_q <= acc_q + a_q;
            end
            a_q <= {a_q[NUMW-2:0], 1'b0};
            b_q <= {1'b0, b_q[SW-1:1]};
          end
        end
        OP_DIV: begin
          a_q   <= {a_q[NUMW-2:0], 1'b0};
          rem_q <= ge ? (rem_sh - {1'b0, b_q[NW-1:0]}) : rem_sh;
          acc_q <= {acc_q[NUMW-2:0], ge};
        end
        OP_SQRT: begin
          if (a_q[63:0] >= trial) begin
            a_q[63:0]   <= a_q[63:0] - trial;
            acc_q[63:0] <= {1'b0, root[63:1]} + one_q;
          end else begin
            acc_q[63:0] <= {1'b0, root[63:1]};
          end
          one_q <= {2'b00, one_q[63:2]};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

endmodule

[hw/rtl/ise_back.sv]
`timescale 1ns / 1ps
// back end: sorted insertion into the interval store and end-of-run statistics
module ise_back #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  ise_pkg::ise_item_t     q_item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [ise_pkg::IvlW-1:0] min_interval_o,
  output logic [ise_pkg::IvlW-1:0] max_interval_o,
  output logic [ise_pkg::IvlW-1:0] mean_interval_o,
  output logic [ise_pkg::IvlW-1:0] median_interval_o,
  output logic [ise_pkg::IvlW-1:0] std_deviation_o
);
  import ise_pkg::*;

  localparam int unsigned NW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned SW   = 32 + NW;
  localparam int unsigned QW   = 64 + NW;
  localparam int unsigned NUMW = 64 + 2 * NW;

  back_state_e state_q, state_d;

  logic [IvlW-1:0] mem_q [MAX_SAMPLES];
  logic [IvlW-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [IvlW-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [NW-1:0]   n_q;
  logic [SW-1:0]   sum_q;
  logic [QW-1:0]   sq_sum_q;
  logic [IvlW-1:0] x_q;
  logic [63:0]     sq_q;
  logic            last_q;
  logic [AW-1:0]   j_q;
  logic [IvlW-1:0] min_q, max_q, mhi_q, med_q, mean_q;
  logic [NUMW-1:0] p1_q, work_q;

  logic            out_valid_q;
  logic [IvlW-1:0] out_min_q, out_max_q, out_mean_q, out_med_q, out_std_q;

  arith_req_t      req;
  logic [NUMW-1:0] op_a;
  logic [SW-1:0]   op_b;
  logic            ar_done;
  logic [NUMW-1:0] ar_res;
  logic            out_free;
  logic [IvlW:0]   mid_sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign mid_sum  = {1'b0, mhi_q} + {1'b0, rdata_q};

  ise_arith #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_arith (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .a_i   (op_a),
    .b_i   (op_b),
    .done_o(ar_done),
    .res_o (ar_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (q_valid_i) state_d = S_INS_RD;
      S_INS_RD:  state_d = (j_q == '0) ? S_ACC : S_INS_CMP;
      S_INS_CMP: state_d = (rdata_q > x_q) ? S_INS_RD : S_ACC;
      S_ACC:     state_d = last_q ? S_RD0 : S_IDLE;
      S_RD0:     state_d = S_RD1;
      S_RD1:     state_d = S_RD2;
      S_RD2:     state_d = S_RD3;
      S_RD3:     state_d = S_RD4;
      S_RD4:     state_d = S_MEAN_GO;
      S_MEAN_GO: state_d = S_MEAN_W;
      S_MEAN_W:  if (ar_done) state_d = S_MUL1_GO;
      S_MUL1_GO: state_d = S_MUL1_W;
      S_MUL1_W:  if (ar_done) state_d = S_MUL2_GO;
      S_MUL2_GO: state_d = S_MUL2_W;
      S_MUL2_W:  if (ar_done) state_d = S_DIV1_GO;
      S_DIV1_GO: state_d = S_DIV1_W;
      S_DIV1_W:  if (ar_done) state_d = S_DIV2_GO;
      S_DIV2_GO: state_d = S_DIV2_W;
      S_DIV2_W:  if (ar_done) state_d = S_SQRT_GO;
      S_SQRT_GO: state_d = S_SQRT_W;
      S_SQRT_W:  if (ar_done) state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = x_q;
    mem_raddr = '0;
    req.start = 1'b0;
    req.op    = OP_MUL;
    op_a      = work_q;
    op_b      = SW'(n_q);
    case (state_q)
      S_IDLE:   pop_o = q_valid_i;
      S_INS_RD: begin
        mem_raddr = j_q - 1'b1;
        if (j_q == '0) begin
          mem_we = 1'b1;
        end
      end
      S_INS_CMP: begin
        mem_we = 1'b1;
        if (rdata_q > x_q) begin
          mem_wdata = rdata_q;
        end
      end
      S_RD1: mem_raddr = AW'(n_q - 1'b1);
      S_RD2: mem_raddr = AW'(n_q >> 1);
      S_RD3: mem_raddr = n_q[0] ? AW'(n_q >> 1) : AW'((n_q >> 1) - 1'b1);
      S_MEAN_GO: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
        op_a      = NUMW'(sum_q);
      end
      S_MUL1_GO: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        op_a      = NUMW'(sq_sum_q);
      end
      S_MUL2_GO: begin
        req.start = 1'b1;
        req.op    = OP_MUL;
        op_a      = NUMW'(sum_q);
        op_b      = sum_q;
      end
      S_DIV1_GO, S_DIV2_GO: begin
        req.start = 1'b1;
        req.op    = OP_DIV;
      end
      S_SQRT_GO: begin
        req.start = 1'b1;
        req.op    = OP_SQRT;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q    <= q_item_i.interval;
        last_q <= q_item_i.last;
        sq_q   <= 64'(q_item_i.interval) * 64'(q_item_i.interval);
        j_q    <= AW'(n_q);
      end
      S_INS_CMP: if (rdata_q > x_q) j_q <= j_q - 1'b1;
      S_RD1:     min_q <= rdata_q;
      S_RD2:     max_q <= rdata_q;
      S_RD3:     mhi_q <= rdata_q;
      S_RD4:     med_q <= mid_sum[IvlW:1];
      S_MEAN_W:  if (ar_done) mean_q <= ar_res[IvlW-1:0];
      S_MUL1_W:  if (ar_done) p1_q <= ar_res;
      S_MUL2_W:  if (ar_done) work_q <= p1_q - ar_res;
      S_DIV1_W, S_DIV2_W, S_SQRT_W: if (ar_done) work_q <= ar_res;
      default:   x_q <= x_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_min_q  <= min_q;
      out_max_q  <= max_q;
      out_mean_q <= mean_q;
      out_med_q  <= med_q;
      out_std_q  <= work_q[IvlW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      sum_q       <= '0;
      sq_sum_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_ACC) begin
        n_q      <= n_q + 1'b1;
        sum_q    <= sum_q + SW'(x_q);
        sq_sum_q <= sq_sum_q + QW'(sq_q);
      end
      if (state_q == S_OUT && out_free) begin
        n_q         <= '0;
        sum_q       <= '0;
        sq_sum_q    <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign min_interval_o    = out_min_q;
  assign max_interval_o    = out_max_q;
  assign mean_interval_o   = out_mean_q;
  assign median_interval_o = out_med_q;
  assign std_deviation_o   = out_std_q;

endmodule

[hw/rtl/interval_statistics_engine_core.sv]
`timescale 1ns / 1ps
// top level of the interval statistics engine
// a timestamp is taken unless the queue is full; an interval is inserted by moving
//   each larger stored entry up one place until it reaches its sorted slot
// end of run: min, max and median are read from the store, then the mean and
//   deviation come from the shared iterative multiply/divide/square-root unit
// reset: async active low; empty run, no reference, sample_count 1024, no clearing pass
module interval_statistics_engine_core #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ise_pkg::CfgW-1:0]   sample_count_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ise_pkg::StampW-1:0] timestamp_us_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ise_pkg::IvlW-1:0]   min_interval_o,
  output logic [ise_pkg::IvlW-1:0]   max_interval_o,
  output logic [ise_pkg::IvlW-1:0]   mean_interval_o,
  output logic [ise_pkg::IvlW-1:0]   median_interval_o,
  output logic [ise_pkg::IvlW-1:0]   std_deviation_o
);
  import ise_pkg::*;

  logic [CfgW-1:0] sample_count_q;
  logic            push, full, pop, q_valid;
  ise_item_t       item_in, item_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= CfgReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      sample_count_q <= sample_count_i;
    end
  end

  ise_front #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_count_i(sample_count_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .timestamp_us_i(timestamp_us_i),
    .push_o        (push),
    .item_o        (item_in),
    .full_i        (full)
  );

  ise_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (item_out)
  );

  ise_back #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (item_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .min_interval_o   (min_interval_o),
    .max_interval_o   (max_interval_o),
    .mean_interval_o  (mean_interval_o),
    .median_interval_o(median_interval_o),
    .std_deviation_o  (std_deviation_o)
  );

endmodule

[hw/rtl/ise_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the interval statistics engine and their binding
module ise_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [ise_pkg::IvlW-1:0] min_interval_o,
  input logic [ise_pkg::IvlW-1:0] max_interval_o,
  input logic [ise_pkg::IvlW-1:0] mean_interval_o,
  input logic [ise_pkg::IvlW-1:0] median_interval_o,
  input logic [ise_pkg::IvlW-1:0] std_deviation_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> min_interval_o <= max_interval_o)
    else $error("minimum above maximum");

  a_mean_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_interval_o >= min_interval_o) && (mean_interval_o <= max_interval_o))
    else $error("mean outside range");

  a_med_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (median_interval_o >= min_interval_o) &&
                    (median_interval_o <= max_interval_o))
    else $error("median outside range");

  a_std_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> std_deviation_o <= (max_interval_o - min_interval_o))
    else $error("deviation above range");

endmodule

bind interval_statistics_engine_core ise_checker u_ise_checker (.*);
